@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the RTL. Each macro expects clk and
// rst_n in scope and is silent while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When ante holds, cons must hold at the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rgbkf_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbkf_pkg
// Widths, register indexes, kernel codes and the per-channel kernel
// arithmetic for the RGB 3x3 kernel filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbkf_pkg;

    // Geometry
    localparam int MAX_COLS    = 2048;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int CHANNELS    = 3;
    localparam int SAMPLE_BITS = 8;
    localparam int PIX_W       = CHANNELS * SAMPLE_BITS;
    localparam int REG_W       = 12;
    localparam int MODE_W      = 3;
    localparam int REG_IDX_W   = 3;
    localparam int OUT_W       = 23;
    localparam int PEND_W      = $clog2(MAX_COLS + 2);
    localparam int DIVC_W      = $clog2(OUT_W + 1);

    // Kernel arithmetic
    localparam int SAMPLE_MAX     = 255;
    localparam int EDGE_CENTRE    = 8;
    localparam int SHARPEN_CENTRE = 5;
    localparam int DIV_BOX        = 9;
    localparam int DIV_GAUSS      = 16;
    localparam int NSUM_W         = SAMPLE_BITS + 2;
    localparam int SUM_W          = 14;
    localparam int MAG_W          = SUM_W - 1;
    localparam int PROD_W         = 2 * MAG_W;
    localparam int RECIP_SHIFT    = 16;
    localparam int RECIP_BOX      = (2**RECIP_SHIFT + 2*DIV_BOX - 1) / (2*DIV_BOX);
    localparam int GAUSS_SHIFT    = $clog2(DIV_GAUSS);

    // Kernel codes
    localparam logic [MODE_W-1:0] MODE_EDGE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SHARPEN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BOX      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GAUSS    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 3'd4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEL_COL_START = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SEL_COL_END   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SEL_ROW_START = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SEL_ROW_END   = 3'd6;

    // Register reset values
    localparam logic [REG_W-1:0] RST_FRAME_COLS    = 12'd640;
    localparam logic [REG_W-1:0] RST_FRAME_ROWS    = 12'd480;
    localparam logic [REG_W-1:0] RST_SEL_COL_START = 12'd0;
    localparam logic [REG_W-1:0] RST_SEL_COL_END   = 12'd640;
    localparam logic [REG_W-1:0] RST_SEL_ROW_START = 12'd0;
    localparam logic [REG_W-1:0] RST_SEL_ROW_END   = 12'd480;

    typedef logic [PIX_W-1:0] pixel_t;

    // Request held in the compute stage
    typedef struct packed {
        logic              valid;
        logic              pixel;       // 1 pixel request, 0 drain request
        logic              emit;        // produces a result
        logic              filt;        // interior and selected: run the kernel
        logic              from_upper;  // drain: centre comes from upper store
        logic              last;        // last pixel of the frame
        logic              fwd;         // store read hit the write in flight
        logic [MODE_W-1:0] mode;
        logic [COL_W-1:0]  addr;
        pixel_t            px;
    } s1_t;

    // One colour channel: weighted sum from corner, edge and centre
    // taps, then divide, round half up and clamp to 0..255.
    function automatic logic [SAMPLE_BITS-1:0] filter_channel(
        input logic [MODE_W-1:0]      mode,
        input logic [NSUM_W-1:0]      corner_sum,
        input logic [NSUM_W-1:0]      edge_sum,
        input logic [SAMPLE_BITS-1:0] centre
    );
        logic signed [SUM_W-1:0] cs;
        logic signed [SUM_W-1:0] es;
        logic signed [SUM_W-1:0] cc;
        logic signed [SUM_W-1:0] s;
        logic [MAG_W-1:0]        mag;
        logic [MAG_W-1:0]        num;
        logic [PROD_W-1:0]       prod;
        logic [MAG_W-1:0]        q;
        cs = $signed({{(SUM_W-NSUM_W){1'b0}}, corner_sum});
        es = $signed({{(SUM_W-NSUM_W){1'b0}}, edge_sum});
        cc = $signed({{(SUM_W-SAMPLE_BITS){1'b0}}, centre});
        unique case (mode)
            MODE_EDGE:    s = cc * SUM_W'(EDGE_CENTRE) - cs - es;
            MODE_SHARPEN: s = cc * SUM_W'(SHARPEN_CENTRE) - es;
            MODE_BOX:     s = cs + es + cc;
            MODE_GAUSS:   s = cs + (es <<< 1) + (cc <<< 2);
            default:      s = cc;
        endcase
        mag  = s[MAG_W-1:0];
        num  = '0;
        prod = '0;
        unique case (mode)
            MODE_BOX:
            begin
                // (2s + 9) / 18 by reciprocal; exact for sums this small
                num  = (mag << 1) + MAG_W'(DIV_BOX);
                prod = PROD_W'(num) * PROD_W'(RECIP_BOX);
                q    = MAG_W'(prod >> RECIP_SHIFT);
            end
            MODE_GAUSS: q = (mag + MAG_W'(DIV_GAUSS / 2)) >> GAUSS_SHIFT;
            default:    q = mag;
        endcase
        if (s < 0)
            filter_channel = '0;
        else if (q > MAG_W'(SAMPLE_MAX))
            filter_channel = SAMPLE_BITS'(SAMPLE_MAX);
        else
            filter_channel = q[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/rgb_3x3_kernel_filter.sv @@
// ----------------------------------------------------------------------------
// rgb_3x3_kernel_filter
// Path: a request that releases a result is registered in the compute stage,
//   then its result in the output register; output lags input by a row plus one.
// Throughput: one request per cycle unless the output stalls. A write to frame_cols
//   holds s_axis_tready low while a bit-serial divider rebuilds the output row/col.
// Reset: asynchronous, registers to reset values, stores left unwritten.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgb_3x3_kernel_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rgbkf_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [rgbkf_pkg::REG_W-1:0]     cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rgbkf_pkg::PIX_W-1:0]     s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                            s_axis_tuser,  // func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rgbkf_pkg::PIX_W-1:0]     m_axis_tdata,  // red_out, green_out, blue_out
    output logic                            m_axis_tlast   // frame_end
);
    import rgbkf_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [REG_W-1:0]  cols_reg;
    logic [REG_W-1:0]  rows_reg;
    logic [REG_W-1:0]  sel_col_start_reg;
    logic [REG_W-1:0]  sel_col_end_reg;
    logic [REG_W-1:0]  sel_row_start_reg;
    logic [REG_W-1:0]  sel_row_end_reg;

    // Position and occupancy
    logic [COL_W-1:0]  in_col_reg;
    logic [COL_W-1:0]  in_col_next;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic [OUT_W-1:0]  out_count_reg;
    logic [OUT_W-1:0]  out_count_next;
    logic [OUT_W-1:0]  out_row_reg;
    logic [OUT_W-1:0]  out_row_next;
    logic [COL_W-1:0]  out_col_reg;
    logic [COL_W-1:0]  out_col_next;

    // Divider for output position after a column count change
    logic              div_busy_reg;
    logic [DIVC_W-1:0] div_cnt_reg;
    logic [OUT_W-1:0]  div_quo_reg;
    logic [REG_W-1:0]  div_rem_reg;
    logic [REG_W:0]    div_rem_sh;
    logic              div_ge;
    logic [REG_W-1:0]  div_rem_new;
    logic [OUT_W-1:0]  div_quo_new;

    // Line stores and window
    pixel_t upper_mem  [MAX_COLS];
    pixel_t middle_mem [MAX_COLS];
    pixel_t up_rd_reg;
    pixel_t mid_rd_reg;
    pixel_t fwd_up_reg;
    pixel_t fwd_mid_reg;
    pixel_t win_reg [6];

    // Compute stage and output register
    s1_t    s1_reg;
    s1_t    s1_next;
    logic   s1_go;
    pixel_t up_eff;
    pixel_t mid_eff;
    pixel_t result;
    logic   out_valid_reg;
    pixel_t out_data_reg;
    logic   out_last_reg;

    // Request decode
    logic [REG_W-1:0] cols_eff;
    logic [REG_W-1:0] rows_eff;
    logic [OUT_W-1:0] rows_ext;
    logic [REG_W-1:0] col_cur;
    logic [REG_W-1:0] col_inc;
    logic [OUT_W-1:0] row_inc;
    logic [REG_W-1:0] in_col_inc;
    logic             accept;
    logic             is_pixel;
    logic             full;
    logic             emit0;
    logic             frame_last;
    logic             interior;
    logic             selected;
    logic [COL_W-1:0] rd_addr;

    // Effective frame size
    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = REG_W'(1);
        else if (cols_reg > REG_W'(MAX_COLS))
            cols_eff = REG_W'(MAX_COLS);
        else
            cols_eff = cols_reg;
        rows_eff = (rows_reg == '0) ? REG_W'(1) : rows_reg;
        rows_ext = OUT_W'(rows_eff);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDENTITY;
            cols_reg          <= RST_FRAME_COLS;
            rows_reg          <= RST_FRAME_ROWS;
            sel_col_start_reg <= RST_SEL_COL_START;
            sel_col_end_reg   <= RST_SEL_COL_END;
            sel_row_start_reg <= RST_SEL_ROW_START;
            sel_row_end_reg   <= RST_SEL_ROW_END;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FILTER_MODE:   mode_reg          <= cfg_wdata[MODE_W-1:0];
                REG_FRAME_COLS:    cols_reg          <= cfg_wdata;
                REG_FRAME_ROWS:    rows_reg          <= cfg_wdata;
                REG_SEL_COL_START: sel_col_start_reg <= cfg_wdata;
                REG_SEL_COL_END:   sel_col_end_reg   <= cfg_wdata;
                REG_SEL_ROW_START: sel_row_start_reg <= cfg_wdata;
                REG_SEL_ROW_END:   sel_row_end_reg   <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Handshake
    assign s1_go = s1_reg.valid && (!s1_reg.emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !div_busy_reg && (!s1_reg.valid || s1_go);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Decode the incoming request against the current positions
    always_comb
    begin
        is_pixel   = !s_axis_tuser;
        full       = pending_reg > cols_eff;
        emit0      = is_pixel ? full : (pending_reg != '0);
        col_cur    = {1'b0, out_col_reg};
        col_inc    = col_cur + REG_W'(1);
        row_inc    = out_row_reg + OUT_W'(1);
        in_col_inc = {1'b0, in_col_reg} + REG_W'(1);
        frame_last = (out_row_reg >= rows_ext)
                  || ((row_inc == rows_ext) && (col_inc >= cols_eff));
        interior   = (out_row_reg != '0) && (row_inc < rows_ext)
                  && (out_col_reg != '0) && (col_inc < cols_eff);
        selected   = (col_cur >= sel_col_start_reg) && (col_cur < sel_col_end_reg)
                  && (out_row_reg >= OUT_W'(sel_row_start_reg))
                  && (out_row_reg < OUT_W'(sel_row_end_reg));
        rd_addr    = is_pixel ? in_col_reg : out_col_reg;

        // Next positions
        in_col_next    = in_col_reg;
        pending_next   = pending_reg;
        out_count_next = out_count_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        if (accept)
        begin
            if (is_pixel)
            begin
                in_col_next = (in_col_inc >= cols_eff) ? '0 : in_col_inc[COL_W-1:0];
                if (!full)
                    pending_next = pending_reg + PEND_W'(1);
            end
            else if (pending_reg != '0)
            begin
                pending_next = pending_reg - PEND_W'(1);
            end
            if (emit0)
            begin
                if (frame_last)
                begin
                    out_count_next = '0;
                    out_row_next   = '0;
                    out_col_next   = '0;
                end
                else
                begin
                    out_count_next = out_count_reg + OUT_W'(1);
                    if (col_inc >= cols_eff)
                    begin
                        out_col_next = '0;
                        out_row_next = row_inc;
                    end
                    else
                    begin
                        out_col_next = col_inc[COL_W-1:0];
                    end
                end
            end
        end

        // Compute-stage request
        s1_next.valid      = 1'b1;
        s1_next.pixel      = is_pixel;
        s1_next.emit       = emit0;
        s1_next.filt       = is_pixel && interior && selected;
        s1_next.from_upper = full;
        s1_next.last       = frame_last;
        s1_next.fwd        = s1_reg.valid && s1_reg.pixel && (s1_reg.addr == rd_addr);
        s1_next.mode       = mode_reg;
        s1_next.addr       = rd_addr;
        s1_next.px         = s_axis_tdata;
    end

    // One restoring division step per cycle
    always_comb
    begin
        div_rem_sh  = {div_rem_reg, div_quo_reg[OUT_W-1]};
        div_ge      = div_rem_sh >= {1'b0, cols_eff};
        div_rem_new = div_ge ? REG_W'(div_rem_sh - {1'b0, cols_eff})
                             : div_rem_sh[REG_W-1:0];
        div_quo_new = {div_quo_reg[OUT_W-2:0], div_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_quo_reg  <= '0;
            div_rem_reg  <= '0;
        end
        else
        begin
            // A new column count restarts the division
            if (cfg_we && (cfg_addr == REG_FRAME_COLS))
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DIVC_W'(OUT_W);
                div_quo_reg  <= out_count_next;
                div_rem_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_quo_reg <= div_quo_new;
                div_rem_reg <= div_rem_new;
                div_cnt_reg <= div_cnt_reg - DIVC_W'(1);
                if (div_cnt_reg == DIVC_W'(1))
                    div_busy_reg <= 1'b0;
            end
        end
    end

    // Position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            pending_reg   <= '0;
            out_count_reg <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            pending_reg   <= pending_next;
            out_count_reg <= out_count_next;
            if (div_busy_reg && (div_cnt_reg == DIVC_W'(1)))
            begin
                out_row_reg <= div_quo_new;
                out_col_reg <= div_rem_new[COL_W-1:0];
            end
            else
            begin
                out_row_reg <= out_row_next;
                out_col_reg <= out_col_next;
            end
        end
    end

    // Compute-stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else if (accept)
            s1_reg <= s1_next;
        else if (s1_go)
            s1_reg.valid <= 1'b0;
    end

    // Store reads (resolved against the write in flight)
    assign up_eff  = s1_reg.fwd ? fwd_up_reg  : up_rd_reg;
    assign mid_eff = s1_reg.fwd ? fwd_mid_reg : mid_rd_reg;

    // Line stores: write in the compute stage, registered read on accept
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_reg.pixel)
        begin
            upper_mem[s1_reg.addr]  <= mid_eff;
            middle_mem[s1_reg.addr] <= s1_reg.px;
        end
        if (accept)
        begin
            up_rd_reg  <= upper_mem[rd_addr];
            mid_rd_reg <= middle_mem[rd_addr];
        end
    end

    // Values being written this cycle, for a read of the same column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= s1_reg.px;
        end
    end

    // Kernel per channel: taps 0..2 left column, 3..5 centre column
    always_comb
    begin
        logic [NSUM_W-1:0]      cs;
        logic [NSUM_W-1:0]      es;
        logic [SAMPLE_BITS-1:0] c;
        pixel_t                 filt_px;
        filt_px = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            cs = NSUM_W'(win_reg[0][k*SAMPLE_BITS +: SAMPLE_BITS])
               + NSUM_W'(up_eff[k*SAMPLE_BITS +: SAMPLE_BITS])
               + NSUM_W'(win_reg[2][k*SAMPLE_BITS +: SAMPLE_BITS])
               + NSUM_W'(s1_reg.px[k*SAMPLE_BITS +: SAMPLE_BITS]);
            es = NSUM_W'(win_reg[3][k*SAMPLE_BITS +: SAMPLE_BITS])
               + NSUM_W'(win_reg[1][k*SAMPLE_BITS +: SAMPLE_BITS])
               + NSUM_W'(mid_eff[k*SAMPLE_BITS +: SAMPLE_BITS])
               + NSUM_W'(win_reg[5][k*SAMPLE_BITS +: SAMPLE_BITS]);
            c  = win_reg[4][k*SAMPLE_BITS +: SAMPLE_BITS];
            filt_px[k*SAMPLE_BITS +: SAMPLE_BITS] = filter_channel(s1_reg.mode, cs, es, c);
        end
        if (!s1_reg.pixel)
            result = s1_reg.from_upper ? up_eff : mid_eff;
        else if (s1_reg.filt)
            result = filt_px;
        else
            result = win_reg[4];
    end

    // Window shift on each pixel request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_go && s1_reg.pixel)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up_eff;
            win_reg[4] <= mid_eff;
            win_reg[5] <= s1_reg.px;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_reg.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_reg.emit)
        begin
            out_data_reg <= result;
            out_last_reg <= s1_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks
    `ASSERT_ALWAYS(a_out_col_bound, div_busy_reg || ({1'b0, out_col_reg} < cols_eff), "output column beyond frame width")
    `ASSERT_NEXT(a_emit_lands, s1_go && s1_reg.emit, out_valid_reg, "result lost on its way to the output register")
    `ASSERT_NEXT(a_s1_hold, s1_reg.valid && !s1_go, s1_reg.valid && $stable(s1_reg.addr) && $stable(s1_reg.px), "stalled compute stage changed")

endmodule

`default_nettype wire

@@ tb/tb_rgb_3x3_kernel_filter.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_3x3_kernel_filter
// Self-checking bench for the streaming RGB 3x3 kernel filter. Pixel and
// drain requests are queued by the stimulus process, pushed out by a
// negedge driver, and tracked at the rising edge by a line-buffer predictor
// that mirrors the block's window, row stores and output position. Results
// are compared field by field against the oldest expected pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb_3x3_kernel_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbkf_pkg::*;

    localparam int unsigned LIMIT_CYCLES    = 600000;
    localparam int unsigned SETTLE_LIMIT    = 200000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned RANDOM_REQUESTS = 1850;
    localparam int unsigned MAX_REPORTS     = 40;
    localparam int unsigned REG_MAX         = 4095;

    typedef struct packed {
        logic   drain;
        pixel_t px;
    } request_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red;
        logic [SAMPLE_BITS-1:0] green;
        logic [SAMPLE_BITS-1:0] blue;
        logic                   frame_end;
    } result_t;

    // Block interface
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr      = '0;
    logic [REG_W-1:0]     cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata  = '0;  // red_in, green_in, blue_in
    logic                 s_axis_tuser  = 1'b0; // func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;        // red_out, green_out, blue_out
    logic                 m_axis_tlast;        // frame_end

    // Register copies seen by the predictor
    logic [MODE_W-1:0] cur_mode    = MODE_IDENTITY;
    logic [REG_W-1:0]  cur_cols    = RST_FRAME_COLS;
    logic [REG_W-1:0]  cur_rows    = RST_FRAME_ROWS;
    logic [REG_W-1:0]  cur_sel_cs  = RST_SEL_COL_START;
    logic [REG_W-1:0]  cur_sel_ce  = RST_SEL_COL_END;
    logic [REG_W-1:0]  cur_sel_rs  = RST_SEL_ROW_START;
    logic [REG_W-1:0]  cur_sel_re  = RST_SEL_ROW_END;

    // Predictor state: two row stores, 2x3 window, positions, backlog
    pixel_t      upper_line  [MAX_COLS];
    pixel_t      middle_line [MAX_COLS];
    pixel_t      win         [6];
    int unsigned in_col  = 0;
    int unsigned in_row  = 0;
    int unsigned out_pos = 0;
    int unsigned backlog = 0;

    request_t    pending_requests [$];
    result_t     expected_pixels  [$];

    bit          request_taken   = 1'b0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned error_count     = 0;
    int unsigned results_checked = 0;
    int unsigned requests_sent   = 0;
    int unsigned settings_run    = 0;
    int unsigned cycle_count     = 0;

    rgb_3x3_kernel_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Kernel arithmetic
    // ------------------------------------------------------------------

    // Tap weight; taps are row-major, corners even, edges odd, centre 4
    function automatic int tap_weight(input logic [MODE_W-1:0] mode, input int idx);
        int kind;
        kind = (idx == 4) ? 2 : (idx % 2);
        case (mode)
            MODE_EDGE:    tap_weight = (kind == 2) ? EDGE_CENTRE : -1;
            MODE_SHARPEN: tap_weight = (kind == 2) ? SHARPEN_CENTRE : ((kind == 1) ? -1 : 0);
            MODE_BOX:     tap_weight = 1;
            MODE_GAUSS:   tap_weight = (kind == 2) ? 4 : ((kind == 1) ? 2 : 1);
            default:      tap_weight = (kind == 2) ? 1 : 0;
        endcase
    endfunction

    function automatic pixel_t kernel_pixel(input logic [MODE_W-1:0] mode,
                                            input logic [8:0][PIX_W-1:0] nb);
        int     acc;
        int     q;
        int     dv;
        int     ch;
        int     i;
        pixel_t r;
        r  = '0;
        dv = (mode == MODE_BOX) ? DIV_BOX : ((mode == MODE_GAUSS) ? DIV_GAUSS : 1);
        for (ch = 0; ch < CHANNELS; ch++)
        begin
            acc = 0;
            for (i = 0; i < 9; i++)
                acc += tap_weight(mode, i) * int'(nb[i][ch*SAMPLE_BITS +: SAMPLE_BITS]);
            // round half up after the divide, clamp to sample range
            if (acc < 0)
                q = 0;
            else
            begin
                q = (2 * acc + dv) / (2 * dv);
                if (q > SAMPLE_MAX)
                    q = SAMPLE_MAX;
            end
            r[ch*SAMPLE_BITS +: SAMPLE_BITS] = q[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic int unsigned eff_cols();
        if (cur_cols == 0)
            return 1;
        if (cur_cols > MAX_COLS)
            return MAX_COLS;
        return cur_cols;
    endfunction

    function automatic int unsigned eff_rows();
        return (cur_rows == 0) ? 1 : cur_rows;
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic push_result(input pixel_t px, input int unsigned total);
        result_t r;
        r.red       = px[7:0];
        r.green     = px[15:8];
        r.blue      = px[23:16];
        r.frame_end = (out_pos + 1 >= total);
        out_pos     = r.frame_end ? 0 : out_pos + 1;
        expected_pixels.push_back(r);
    endtask

    task automatic predict_filter(input logic drain, input pixel_t px);
        int unsigned              cols;
        int unsigned              rows;
        int unsigned              lag;
        int unsigned              total;
        int unsigned              orow;
        int unsigned              ocol;
        logic [MODE_W-1:0]        mode;
        pixel_t                   up;
        pixel_t                   mid;
        pixel_t                   res;
        logic [8:0][PIX_W-1:0]    nb;
        bit                       interior;
        bit                       selected;
        cols  = eff_cols();
        rows  = eff_rows();
        lag   = cols + 1;
        total = cols * rows;
        orow  = out_pos / cols;
        ocol  = out_pos % cols;
        mode  = (cur_mode > MODE_IDENTITY) ? MODE_IDENTITY : cur_mode;
        if (!drain)
        begin
            up  = upper_line[in_col];
            mid = middle_line[in_col];
            upper_line[in_col]  = mid;
            middle_line[in_col] = px;
            // a full backlog releases the pixel one row plus one back
            if (backlog >= lag)
            begin
                res      = win[4];
                interior = orow >= 1 && orow + 1 < rows && ocol >= 1 && ocol + 1 < cols;
                selected = ocol >= cur_sel_cs && ocol < cur_sel_ce
                           && orow >= cur_sel_rs && orow < cur_sel_re;
                if (interior && selected)
                begin
                    nb[0] = win[0]; nb[1] = win[3]; nb[2] = up;
                    nb[3] = win[1]; nb[4] = win[4]; nb[5] = mid;
                    nb[6] = win[2]; nb[7] = win[5]; nb[8] = px;
                    res = kernel_pixel(mode, nb);
                end
                push_result(res, total);
            end
            else
                backlog++;
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = up;
            win[4] = mid;
            win[5] = px;
            if (in_col + 1 >= cols)
            begin
                in_col = 0;
                in_row = (in_row + 1 >= rows) ? 0 : in_row + 1;
            end
            else
                in_col++;
        end
        else if (backlog != 0)
        begin
            // drain: oldest pending pixel leaves unfiltered
            res = (backlog >= lag) ? upper_line[ocol] : middle_line[ocol];
            backlog--;
            push_result(res, total);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned seen);
        if (error_count < MAX_REPORTS)
            $display("MISMATCH %s: expected %0d, got %0d (result %0d, cycle %0d)",
                     what, want, seen, results_checked, cycle_count);
        error_count++;
    endtask

    // Output check first, then the request accepted at this edge
    always @(posedge clk)
    begin : watch_block
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.red       = m_axis_tdata[7:0];
                got.green     = m_axis_tdata[15:8];
                got.blue      = m_axis_tdata[23:16];
                got.frame_end = m_axis_tlast;
                if (expected_pixels.size() == 0)
                    report_mismatch("result with nothing expected", 0, 1);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red != want.red)
                        report_mismatch("red_out", want.red, got.red);
                    if (got.green != want.green)
                        report_mismatch("green_out", want.green, got.green);
                    if (got.blue != want.blue)
                        report_mismatch("blue_out", want.blue, got.blue);
                    if (got.frame_end != want.frame_end)
                        report_mismatch("frame_end", want.frame_end, got.frame_end);
                    results_checked++;
                end
            end
            request_taken = s_axis_tvalid && s_axis_tready;
            if (request_taken)
            begin
                predict_filter(s_axis_tuser, s_axis_tdata);
                requests_sent++;
            end
        end
        else
            request_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Driver and receiver, both on the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin : feed_requests
        request_t req;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || request_taken)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= req.drain;
                s_axis_tdata  <= req.px;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", LIMIT_CYCLES);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= REG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_FILTER_MODE:   cur_mode   = MODE_W'(value);
            REG_FRAME_COLS:    cur_cols   = REG_W'(value);
            REG_FRAME_ROWS:    cur_rows   = REG_W'(value);
            REG_SEL_COL_START: cur_sel_cs = REG_W'(value);
            REG_SEL_COL_END:   cur_sel_ce = REG_W'(value);
            REG_SEL_ROW_START: cur_sel_rs = REG_W'(value);
            REG_SEL_ROW_END:   cur_sel_re = REG_W'(value);
            default: ;
        endcase
    endtask

    // Column count goes last: it starts the block's position rebuild
    task automatic configure(input int unsigned mode, cols, rows, cs, ce, rs, re);
        write_reg(REG_FILTER_MODE, mode);
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_SEL_COL_START, cs);
        write_reg(REG_SEL_COL_END, ce);
        write_reg(REG_SEL_ROW_START, rs);
        write_reg(REG_SEL_ROW_END, re);
        write_reg(REG_FRAME_COLS, cols);
        settings_run++;
    endtask

    task automatic queue_request(input logic drain, input pixel_t px);
        request_t req;
        req.drain = drain;
        req.px    = px;
        pending_requests.push_back(req);
    endtask

    // Enough drains to empty the backlog, plus a few that find it empty
    task automatic queue_flush(input int unsigned extra);
        repeat (eff_cols() + 1 + extra)
            queue_request(1'b1, pixel_t'($urandom()));
    endtask

    // Wait until every request is out and every result is back
    task automatic settle_block();
        int unsigned waited;
        waited = 0;
        while ((pending_requests.size() != 0 || s_axis_tvalid
                || expected_pixels.size() != 0) && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_pixels.size() != 0)
        begin
            report_mismatch("results never delivered", expected_pixels.size(), 0);
            expected_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        int     ch;
        p = pixel_t'($urandom());
        case ($urandom_range(0, 3))
            1:
            begin
                // saturated components drive the clamps both ways
                for (ch = 0; ch < CHANNELS; ch++)
                    p[ch*SAMPLE_BITS +: SAMPLE_BITS] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            2: p = {3{p[7:0]}};
            default: ;
        endcase
        return p;
    endfunction

    // Whole frames with stray mid-frame drains, then a flush
    task automatic queue_frames(input int unsigned frames, output int unsigned requests);
        int unsigned i;
        int unsigned pixels;
        int unsigned extra;
        pixels   = frames * eff_cols() * eff_rows();
        requests = 0;
        for (i = 0; i < pixels; i++)
        begin
            if ($urandom_range(99) < 4)
            begin
                queue_request(1'b1, pixel_t'($urandom()));
                requests++;
            end
            queue_request(1'b0, rand_pixel());
            requests++;
        end
        extra = $urandom_range(0, 2);
        queue_flush(extra);
        requests += eff_cols() + 1 + extra;
    endtask

    task automatic small_phase(input int unsigned mode, output int unsigned requests);
        int unsigned cols;
        int unsigned rows;
        int unsigned ec;
        int unsigned er;
        int unsigned cs;
        int unsigned ce;
        int unsigned rs;
        int unsigned re;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        cols = (pick < 3) ? pick : $urandom_range(3, 14);
        pick = $urandom_range(0, 7);
        rows = (pick < 2) ? pick : $urandom_range(2, 7);
        ec   = (cols == 0) ? 1 : cols;
        er   = (rows == 0) ? 1 : rows;
        case ($urandom_range(0, 3))
            0:
            begin
                cs = 0; ce = REG_MAX; rs = 0; re = REG_MAX;
            end
            1:
            begin
                cs = $urandom_range(0, ec);
                ce = $urandom_range(cs, ec + 1);
                rs = $urandom_range(0, er);
                re = $urandom_range(rs, er + 1);
            end
            2:
            begin
                // inverted window: nothing filtered
                cs = $urandom_range(1, ec + 1);
                ce = $urandom_range(0, cs - 1);
                rs = $urandom_range(1, er + 1);
                re = $urandom_range(0, rs - 1);
            end
            default:
            begin
                cs = $urandom_range(0, REG_MAX);
                ce = $urandom_range(0, REG_MAX);
                rs = $urandom_range(0, REG_MAX);
                re = $urandom_range(0, REG_MAX);
            end
        endcase
        configure(mode, cols, rows, cs, ce, rs, re);
        queue_frames($urandom_range(1, 3), requests);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : run_test
        int unsigned i;
        int unsigned phase;
        int unsigned requests;
        int unsigned random_requests;
        pixel_t      px;

        for (i = 0; i < MAX_COLS; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 6; i++)
            win[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 3x4 edge frame, one bright interior pixel and a
        // bright corner; neighbors go negative and clamp to zero
        configure(MODE_EDGE, 3, 4, 0, REG_MAX, 0, REG_MAX);
        queue_request(1'b1, '0);  // drain with nothing pending
        for (i = 0; i < 12; i++)
        begin
            if (i == 0)
                px = 24'hFFFFFF;
            else if (i == 4)
                px = {8'd255, 8'd128, 8'd255};
            else
                px = '0;
            queue_request(1'b0, px);
        end
        queue_flush(1);
        settle_block();

        // Random phases, idling profile rotating per phase
        phase           = 0;
        random_requests = 0;
        while (random_requests < RANDOM_REQUESTS)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 66; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct = 32; recv_stall_pct = 32;
                end
            endcase
            small_phase(phase % 8, requests);
            random_requests += requests;
            settle_block();
            phase++;
        end

        $display("checked %0d results from %0d requests across %0d register settings",
                 results_checked, requests_sent, settings_run);
        $display("covered kernel codes 0-7, widths 0-14, drains mid-frame and on empty");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/rgbkf_pkg.sv
src/rgb_3x3_kernel_filter.sv
tb/tb_rgb_3x3_kernel_filter.sv
